// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the sparse codebook engine checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sce assertion failed");

// next-cycle implication, disabled during reset
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sce assertion failed");

`endif

// ===== hw/rtl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// types, codes and constants shared by the sparse codebook engine
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int ATOMS_DEF   = 64;
    localparam int DIM_MAX_DEF = 64;
    localparam int POS_SPACE   = 64;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 6;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam logic [KIND_W-1:0] KIND_STAGE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_BAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET       = 7'd64;
    localparam logic [CFG_W-1:0] MAX_WIDTH_RESET = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_COMMIT,
        ST_FIRE,
        ST_DECODE,
        ST_QUERY_READ,
        ST_QUERY_CHECK,
        ST_QUERY_END
    } state_t;

endpackage

// ===== hw/rtl/sparse_codebook_engine_top.sv =====
// ----------------------------------------------------------------------------
// sparse_codebook_engine_top
// sparse atom table with staging, commit, decode and position query
// ----------------------------------------------------------------------------
// Handles one item at a time; s_tready is high only while the engine is idle.
// A commit clips the staged positions, retiring one position per cycle while
// clipping is on, and waits for the result register. A fire does one atom
// memory read; the fire marked tlast then emits one decoded position per cycle
// while the result port is free. A query reads each stored atom in turn through
// the single read port of the atom memory. Results leave through a registered
// master port, so a stalled consumer only stalls the engine when a new result is
// ready.
module sparse_codebook_engine_top import sce_pkg::*; #(
    parameter int ATOMS   = ATOMS_DEF,
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // atom_index[5:0], position[11:6], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
    input  logic                  s_tlast,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // value[5:0], zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status[1:0]
    output logic                  m_tlast
);

    localparam int AW = $clog2(ATOMS);
    localparam int CW = $clog2(ATOMS + 1);
    localparam int PW = $clog2(DIM_MAX);
    localparam logic [CW-1:0] ATOMS_C = CW'(ATOMS);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   dim_reg, dim_next;
    logic [CFG_W-1:0]   max_width_reg, max_width_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [DIM_MAX-1:0] staging_reg, staging_next;
    logic [DIM_MAX-1:0] fired_reg, fired_next;
    logic [DIM_MAX-1:0] kept_reg, kept_next;
    logic [DIM_MAX-1:0] rem_reg, rem_next;
    logic [CFG_W-1:0]   cnt_reg, cnt_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]   m_value_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic               m_last_reg;

    logic               s_xfer;
    logic [IDX_W-1:0]   in_idx;
    logic [POS_W-1:0]   in_pos;
    logic               out_free;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [DIM_MAX-1:0] ram_rd_data;

    logic               emit;
    logic [VAL_W-1:0]   emit_value;
    logic [STAT_W-1:0]  emit_status;
    logic               emit_last;

    logic [DIM_MAX-1:0] rem_low;
    logic               clip_done;
    logic               table_full;
    logic               bad_index;
    logic               fire_hit;
    logic [DIM_MAX-1:0] dec_low;
    logic [DIM_MAX-1:0] dec_rest;
    logic [PW-1:0]      dec_pos;
    logic [POS_SPACE-1:0] rd_ext;
    logic               q_hit;
    logic               q_last_atom;
    logic               q_stall;
    logic [DIM_MAX-1:0] stage_bit;
    logic               q_skip;

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign in_idx    = s_tdata[IDX_W-1:0];
    assign in_pos    = s_tdata[IDX_W+POS_W-1:IDX_W];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign rem_low     = rem_reg & (~rem_reg + DIM_MAX'(1));
    assign clip_done   = (rem_reg == '0) || (cnt_reg == max_width_reg);
    assign table_full  = count_reg >= ATOMS_C;
    assign bad_index   = {1'b0, idx_reg} >= CFG_W'(count_reg);
    assign fire_hit    = {1'b0, idx_reg} < CFG_W'(count_reg);
    assign dec_low     = fired_reg & (~fired_reg + DIM_MAX'(1));
    assign dec_rest    = fired_reg & ~dec_low;
    assign rd_ext      = POS_SPACE'(ram_rd_data);
    assign q_hit       = rd_ext[pos_reg];
    assign q_last_atom = (k_reg + 1'b1) == count_reg;
    assign q_stall     = q_hit && pend_reg && !out_free;
    assign stage_bit   = DIM_MAX'(POS_SPACE'(1) << in_pos);
    assign q_skip      = {1'b0, in_pos} >= dim_reg;

    always_comb begin
        dec_pos = '0;
        for (int i = 0; i < DIM_MAX; i++) begin
            if (dec_low[i]) begin
                dec_pos = dec_pos | PW'(i);
            end
        end
    end

    sce_ram #(
        .WIDTH (DIM_MAX),
        .DEPTH (ATOMS)
    ) u_atom_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (kept_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_tuser)
                        KIND_APPEND, KIND_REPLACE: state_next = ST_CLIP;
                        KIND_FIRE:                 state_next = ST_FIRE;
                        KIND_QUERY: begin
                            if (q_skip) begin
                                state_next = ST_IDLE;
                            end else if (count_reg == '0) begin
                                state_next = ST_QUERY_END;
                            end else begin
                                state_next = ST_QUERY_READ;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLIP: begin
                if (clip_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIRE: begin
                state_next = last_reg ? ST_DECODE : ST_IDLE;
            end
            ST_DECODE: begin
                if (out_free && (fired_reg == '0 || dec_rest == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY_READ: begin
                state_next = ST_QUERY_CHECK;
            end
            ST_QUERY_CHECK: begin
                if (!q_stall) begin
                    state_next = q_last_atom ? ST_QUERY_END : ST_QUERY_READ;
                end
            end
            ST_QUERY_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[AW-1:0];
        ram_rd_en   = 1'b0;
        ram_rd_addr = k_reg[AW-1:0];
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = STATUS_OK;
        emit_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                ram_rd_en   = s_tvalid && s_tuser == KIND_FIRE;
                ram_rd_addr = in_idx[AW-1:0];
            end
            ST_COMMIT: begin
                emit = out_free;
                if (kind_reg == KIND_APPEND) begin
                    ram_wr_addr = count_reg[AW-1:0];
                    ram_wr_en   = out_free && !table_full;
                    emit_value  = table_full ? '0 : VAL_W'(count_reg);
                    emit_status = table_full ? STATUS_FULL : STATUS_OK;
                end else begin
                    ram_wr_addr = idx_reg[AW-1:0];
                    ram_wr_en   = out_free && !bad_index;
                    emit_value  = bad_index ? '0 : idx_reg;
                    emit_status = bad_index ? STATUS_BAD : STATUS_OK;
                end
            end
            ST_DECODE: begin
                emit = out_free;
                if (fired_reg == '0) begin
                    emit_status = STATUS_EMPTY;
                end else begin
                    emit_value = VAL_W'(dec_pos);
                    emit_last  = dec_rest == '0;
                end
            end
            ST_QUERY_READ: begin
                ram_rd_en = 1'b1;
            end
            ST_QUERY_CHECK: begin
                emit       = q_hit && pend_reg && out_free;
                emit_value = VAL_W'(pend_idx_reg);
                emit_last  = 1'b0;
            end
            ST_QUERY_END: begin
                emit = out_free;
                if (pend_reg) begin
                    emit_value = VAL_W'(pend_idx_reg);
                end else begin
                    emit_status = STATUS_EMPTY;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        dim_next       = dim_reg;
        max_width_next = max_width_reg;
        count_next     = count_reg;
        staging_next   = staging_reg;
        fired_next     = fired_reg;
        kept_next      = kept_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        m_tvalid_next  = out_free ? emit : m_tvalid_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DIM:       dim_next = cfg_data;
                CFG_MAX_WIDTH: max_width_next = cfg_data;
                default:       dim_next = dim_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    kind_next = s_tuser;
                    idx_next  = in_idx;
                    pos_next  = in_pos;
                    last_next = s_tlast;
                    k_next    = '0;
                    pend_next = 1'b0;
                    case (s_tuser)
                        KIND_STAGE: begin
                            staging_next = staging_reg | stage_bit;
                        end
                        KIND_APPEND, KIND_REPLACE: begin
                            staging_next = '0;
                            cnt_next     = '0;
                            if (max_width_reg == '0) begin
                                kept_next = staging_reg;
                                rem_next  = '0;
                            end else begin
                                kept_next = '0;
                                rem_next  = staging_reg;
                            end
                        end
                        default: begin
                            staging_next = staging_reg;
                        end
                    endcase
                end
            end
            ST_CLIP: begin
                if (!clip_done) begin
                    kept_next = kept_reg | rem_low;
                    rem_next  = rem_reg & ~rem_low;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (out_free && kind_reg == KIND_APPEND && !table_full) begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_FIRE: begin
                if (fire_hit) begin
                    fired_next = fired_reg | ram_rd_data;
                end
            end
            ST_DECODE: begin
                if (out_free) begin
                    fired_next = dec_rest;
                end
            end
            ST_QUERY_CHECK: begin
                if (!q_stall) begin
                    k_next = k_reg + 1'b1;
                    if (q_hit) begin
                        pend_next     = 1'b1;
                        pend_idx_next = k_reg[AW-1:0];
                    end
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dim_reg       <= DIM_RESET;
            max_width_reg <= MAX_WIDTH_RESET;
            count_reg     <= '0;
            staging_reg   <= '0;
            fired_reg     <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            max_width_reg <= max_width_next;
            count_reg     <= count_next;
            staging_reg   <= staging_next;
            fired_reg     <= fired_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kept_reg     <= kept_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        pend_idx_reg <= pend_idx_next;
        if (out_free && emit) begin
            m_value_reg  <= emit_value;
            m_status_reg <= emit_status;
            m_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_value_reg);
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/sce_ram.sv =====
// ----------------------------------------------------------------------------
// sce_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sce_checker.sv =====
// ----------------------------------------------------------------------------
// sce_checker
// port-level checks for the sparse codebook engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sce_checker import sce_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [STAT_W-1:0]     m_tuser,
    input  logic                  m_tlast
);

    logic commit_xfer;
    logic m_stall;

    assign commit_xfer = s_tvalid && s_tready && (s_tuser inside {KIND_APPEND, KIND_REPLACE});
    assign m_stall     = m_tvalid && !m_tready;

    // a stalled result stays offered
    `SCE_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_stall, m_tvalid)

    // a stalled result does not change
    `SCE_ASSERT_NEXT(a_hold_payload, aclk, aresetn, m_stall,
        $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // every error or empty status is a lone result with value zero
    `SCE_ASSERT_NOW(a_status_single, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK,
        m_tlast && m_tdata == '0)

    // an accepted commit makes the engine busy and drops s_tready
    `SCE_ASSERT_NEXT(a_commit_busy, aclk, aresetn, commit_xfer, !s_tready)

endmodule

bind sparse_codebook_engine_top sce_checker u_sce_checker (.*);
